// ----- rtl/bhe_pkg.sv -----
// ----------------------------------------------------------------------------
// bhe_pkg: shared definitions for the byte histogram engine
// Command and answer codes, default sizes and the controller state type.
// ----------------------------------------------------------------------------
package bhe_pkg;

  localparam int BINS_DEF       = 256;
  localparam int COUNT_BITS_DEF = 32;

  // Width of the reported count fields and of the command field.
  localparam int OUT_W  = 32;
  localparam int KIND_W = 3;

  // Command codes carried by the kind field.
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SCAN  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd4;

  // Answer codes carried by the answer_kind field.
  localparam logic ANS_SCAN = 1'b0;
  localparam logic ANS_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_WB,
    ST_READ_RES,
    ST_SCAN,
    ST_SCAN_END,
    ST_EMIT
  } state_t;

endpackage

// ----- rtl/bhe_if.sv -----
// ----------------------------------------------------------------------------
// bhe_if: valid/ready channels of the byte histogram engine
// One interface for the command channel and one for the answer channel.
// ----------------------------------------------------------------------------
interface bhe_in_if;
  logic                        valid;
  logic                        ready;
  logic [bhe_pkg::KIND_W-1:0]  kind;
  logic [7:0]                  voxel;
  logic [7:0]                  bin_index;
  logic [31:0]                 bin_value;

  modport source (output valid, kind, voxel, bin_index, bin_value, input ready);
  modport sink   (input valid, kind, voxel, bin_index, bin_value, output ready);
endinterface

interface bhe_out_if;
  logic                       valid;
  logic                       ready;
  logic                       answer_kind;
  logic [bhe_pkg::OUT_W-1:0]  bin_count;
  logic [bhe_pkg::OUT_W-1:0]  largest_count;
  logic [bhe_pkg::OUT_W-1:0]  smallest_count;

  modport source (output valid, answer_kind, bin_count, largest_count, smallest_count,
                  input ready);
  modport sink   (input valid, answer_kind, bin_count, largest_count, smallest_count,
                  output ready);
endinterface

// ----- rtl/bhe_ram.sv -----
// ----------------------------------------------------------------------------
// bhe_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bhe_ram #(
  parameter int WIDTH = bhe_pkg::COUNT_BITS_DEF,
  parameter int DEPTH = bhe_pkg::BINS_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/byte_histogram_engine_top.sv -----
// ----------------------------------------------------------------------------
// byte_histogram_engine_top: histogram of voxel bytes with saturating bins
// Sequence: an add reads its bin on acceptance and writes it back in ST_ADD_WB;
//   a write goes straight to the RAM; a read answers through ST_READ_RES and
//   ST_EMIT, a scan through ST_SCAN over all bins, ST_SCAN_END and ST_EMIT.
// Flow: one command at a time; the engine takes no new command until an add
//   has done its read-modify-write through the bin RAM's single read port.
// Reset: the extremes return to zero and all ones at once; a clearing pass
//   then zeroes the bin RAM, taking no command; a clear command runs it too.
// ----------------------------------------------------------------------------
module byte_histogram_engine_top #(
  parameter int BINS       = bhe_pkg::BINS_DEF,
  parameter int COUNT_BITS = bhe_pkg::COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bhe_in_if.sink     in_chan,
  bhe_out_if.source  out_chan
);

  localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int OW = bhe_pkg::OUT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(BINS - 1);

  // Controller state and the stored extremes.
  bhe_pkg::state_t        state_r, state_nxt;
  logic [AW-1:0]          ptr_r, ptr_nxt;
  logic [COUNT_BITS-1:0]  largest_r, largest_nxt;
  logic [COUNT_BITS-1:0]  smallest_r, smallest_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Per-command context held while the command is in flight.
  logic [AW-1:0]          addr_r, addr_nxt;
  logic                   addr_ok_r, addr_ok_nxt;
  logic [COUNT_BITS-1:0]  max_acc_r, max_acc_nxt;
  logic [COUNT_BITS-1:0]  min_acc_r, min_acc_nxt;
  logic [COUNT_BITS-1:0]  res_count_r, res_count_nxt;
  logic                   res_kind_r, res_kind_nxt;

  // Answer register.
  logic                   out_kind_r;
  logic [OW-1:0]          out_count_r;
  logic [OW-1:0]          out_largest_r;
  logic [OW-1:0]          out_smallest_r;
  logic                   out_load;

  // Bin RAM ports.
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [COUNT_BITS-1:0]  mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [COUNT_BITS-1:0]  mem_rdata;

  // Decoded command fields.
  logic                   in_accept;
  logic                   voxel_ok;
  logic                   idx_ok;
  logic [AW-1:0]          voxel_addr;
  logic [AW-1:0]          idx_addr;
  logic [COUNT_BITS-1:0]  write_val;
  logic [COUNT_BITS-1:0]  add_val;

  // Running extremes during a scan, with the bin that just came out of the RAM.
  logic                   scan_dv;
  logic [COUNT_BITS-1:0]  max_fold;
  logic [COUNT_BITS-1:0]  min_fold;

  bhe_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BINS)
  ) u_bins (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign in_chan.ready = (state_r == bhe_pkg::ST_IDLE);
  assign in_accept     = in_chan.valid && in_chan.ready;

  // Bytes beyond the bin range are ignored, so the range checks run on the
  // full field before it is cut down to an address.
  assign voxel_ok   = 32'(in_chan.voxel) < 32'(BINS);
  assign idx_ok     = 32'(in_chan.bin_index) < 32'(BINS);
  assign voxel_addr = AW'(in_chan.voxel);
  assign idx_addr   = AW'(in_chan.bin_index);
  assign write_val  = COUNT_BITS'(in_chan.bin_value);

  // Saturating increment: a bin at all ones stays there.
  assign add_val = (mem_rdata == '1) ? mem_rdata : mem_rdata + 1'b1;

  // The scan reads one bin per cycle; the bin read in the previous cycle is
  // folded in, so nothing arrives in the first scan cycle.
  assign scan_dv  = (state_r == bhe_pkg::ST_SCAN_END) || (ptr_r != '0);
  assign max_fold = (scan_dv && (mem_rdata > max_acc_r)) ? mem_rdata : max_acc_r;
  assign min_fold = (scan_dv && (mem_rdata < min_acc_r)) ? mem_rdata : min_acc_r;

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    largest_nxt   = largest_r;
    smallest_nxt  = smallest_r;
    addr_nxt      = addr_r;
    addr_ok_nxt   = addr_ok_r;
    max_acc_nxt   = max_acc_r;
    min_acc_nxt   = min_acc_r;
    res_count_nxt = res_count_r;
    res_kind_nxt  = res_kind_r;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r;
    mem_wdata     = '0;
    mem_raddr     = ptr_r;

    case (state_r)
      bhe_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = '0;
        if (ptr_r == LAST_ADDR) begin
          ptr_nxt   = '0;
          state_nxt = bhe_pkg::ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      bhe_pkg::ST_IDLE: begin
        mem_raddr = (in_chan.kind == bhe_pkg::KIND_ADD) ? voxel_addr : idx_addr;
        if (in_accept) begin
          case (in_chan.kind)
            bhe_pkg::KIND_CLEAR: begin
              largest_nxt  = '0;
              smallest_nxt = '1;
              state_nxt    = bhe_pkg::ST_CLEAR;
            end
            bhe_pkg::KIND_ADD: begin
              if (voxel_ok) begin
                addr_nxt  = voxel_addr;
                state_nxt = bhe_pkg::ST_ADD_WB;
              end
            end
            bhe_pkg::KIND_SCAN: begin
              max_acc_nxt = '0;
              min_acc_nxt = '1;
              state_nxt   = bhe_pkg::ST_SCAN;
            end
            bhe_pkg::KIND_READ: begin
              addr_ok_nxt = idx_ok;
              state_nxt   = bhe_pkg::ST_READ_RES;
            end
            bhe_pkg::KIND_WRITE: begin
              if (idx_ok) begin
                mem_we    = 1'b1;
                mem_waddr = idx_addr;
                mem_wdata = write_val;
                // The smallest count is only tried when the largest compare
                // fails.
                if (write_val > largest_r) begin
                  largest_nxt = write_val;
                end else if (write_val < smallest_r) begin
                  smallest_nxt = write_val;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      bhe_pkg::ST_ADD_WB: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = add_val;
        state_nxt = bhe_pkg::ST_IDLE;
      end

      bhe_pkg::ST_READ_RES: begin
        res_count_nxt = addr_ok_r ? mem_rdata : '0;
        res_kind_nxt  = bhe_pkg::ANS_READ;
        state_nxt     = bhe_pkg::ST_EMIT;
      end

      bhe_pkg::ST_SCAN: begin
        mem_raddr   = ptr_r;
        max_acc_nxt = max_fold;
        min_acc_nxt = min_fold;
        if (ptr_r == LAST_ADDR) begin
          ptr_nxt   = '0;
          state_nxt = bhe_pkg::ST_SCAN_END;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      bhe_pkg::ST_SCAN_END: begin
        largest_nxt   = max_fold;
        smallest_nxt  = min_fold;
        res_count_nxt = '0;
        res_kind_nxt  = bhe_pkg::ANS_SCAN;
        state_nxt     = bhe_pkg::ST_EMIT;
      end

      bhe_pkg::ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = bhe_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bhe_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bhe_pkg::ST_CLEAR;
      ptr_r       <= '0;
      largest_r   <= '0;
      smallest_r  <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      largest_r   <= largest_nxt;
      smallest_r  <= smallest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    addr_ok_r   <= addr_ok_nxt;
    max_acc_r   <= max_acc_nxt;
    min_acc_r   <= min_acc_nxt;
    res_count_r <= res_count_nxt;
    res_kind_r  <= res_kind_nxt;
    if (out_load) begin
      out_kind_r     <= res_kind_r;
      out_count_r    <= OW'(res_count_r);
      out_largest_r  <= OW'(largest_r);
      out_smallest_r <= OW'(smallest_r);
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.answer_kind    = out_kind_r;
  assign out_chan.bin_count      = out_count_r;
  assign out_chan.largest_count  = out_largest_r;
  assign out_chan.smallest_count = out_smallest_r;

  // A finished scan has seen every bin, so its extremes are ordered.
  a_scan_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bhe_pkg::ST_EMIT && res_kind_r == bhe_pkg::ANS_SCAN)
      |-> (largest_r >= smallest_r))
    else $error("scan extremes out of order");

  // The add write-back is the read value plus one, or a saturated bin.
  a_add_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bhe_pkg::ST_ADD_WB)
      |-> (mem_we && ((mem_wdata == mem_rdata + 1'b1) || (mem_rdata == '1))))
    else $error("add write-back is not a saturating increment");

  // An add to a bin in range is followed by its write-back.
  a_add_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_chan.kind == bhe_pkg::KIND_ADD && voxel_ok)
      |=> (state_r == bhe_pkg::ST_ADD_WB))
    else $error("add transaction without write-back");

  // A new answer only ever comes out of the emit state.
  a_answer_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (state_r == bhe_pkg::ST_EMIT) && (res_kind_r == bhe_pkg::ANS_READ ||
                                                   res_count_r == '0))
    else $error("answer loaded outside the emit state");

endmodule

// ----- dv/byte_histogram_engine_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_histogram_engine_top_tb: self-checking bench for the histogram engine
// A short table of commands walks reset values, saturation, the else-if update
// of the extremes on a write, the spare command codes and clear. A long random
// mix follows: voxel adds aimed at a few hot bins, reads, writes of edge and
// random counts, scans and the odd clear. Every answer is checked field by
// field against the table's typed answer or a bit-accurate histogram predictor.
// ----------------------------------------------------------------------------
module byte_histogram_engine_top_tb;

  localparam int          BINS       = bhe_pkg::BINS_DEF;
  localparam int          CNT_W      = bhe_pkg::COUNT_BITS_DEF;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam int          RANDOM_CMDS = 1650;
  localparam int          TIMEOUT_NS  = 4_000_000;

  // Codes 5 to 7 are not commands; the engine must drop them silently.
  localparam logic [bhe_pkg::KIND_W-1:0] KIND_SPARE5 = 3'd5;
  localparam logic [bhe_pkg::KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [bhe_pkg::KIND_W-1:0] KIND_SPARE7 = 3'd7;

  typedef struct packed {
    logic [bhe_pkg::KIND_W-1:0] kind;
    logic [7:0]                 voxel;
    logic [7:0]                 bin_index;
    logic [31:0]                bin_value;
  } command_t;

  typedef struct packed {
    logic                      answer_kind;
    logic [bhe_pkg::OUT_W-1:0] bin_count;
    logic [bhe_pkg::OUT_W-1:0] largest_count;
    logic [bhe_pkg::OUT_W-1:0] smallest_count;
  } answer_t;

  // One row of the directed table. Where "typed" is set, the answer columns
  // hold the expected answer; otherwise the predictor supplies it.
  typedef struct packed {
    logic [bhe_pkg::KIND_W-1:0] kind;
    logic [7:0]                 voxel;
    logic [7:0]                 bin_index;
    logic [31:0]                bin_value;
    bit                         typed;
    logic                       answer_kind;
    logic [bhe_pkg::OUT_W-1:0]  bin_count;
    logic [bhe_pkg::OUT_W-1:0]  largest_count;
    logic [bhe_pkg::OUT_W-1:0]  smallest_count;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [25] = '{
    // Fresh out of reset: bins zero, largest zero, smallest all ones.
    '{bhe_pkg::KIND_READ,  8'd0,   8'd0,   32'd0,         1'b1, bhe_pkg::ANS_READ,
      32'd0, 32'd0, 32'hFFFF_FFFF},
    // A scan over an all-zero histogram pulls smallest down to zero.
    '{bhe_pkg::KIND_SCAN,  8'd0,   8'd0,   32'd0,         1'b1, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    '{bhe_pkg::KIND_READ,  8'd0,   8'd255, 32'd0,         1'b1, bhe_pkg::ANS_READ,
      32'd0, 32'd0, 32'd0},
    // Back-to-back adds to the same bin exercise the read-modify-write path.
    '{bhe_pkg::KIND_ADD,   8'd0,   8'd0,   32'd0,         1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    '{bhe_pkg::KIND_ADD,   8'd0,   8'd0,   32'd0,         1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    '{bhe_pkg::KIND_ADD,   8'd255, 8'd0,   32'd0,         1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    // Load a bin at the top of the range, then add to it: it must stick.
    '{bhe_pkg::KIND_WRITE, 8'd0,   8'd10,  32'hFFFF_FFFF, 1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    '{bhe_pkg::KIND_ADD,   8'd10,  8'd0,   32'd0,         1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    '{bhe_pkg::KIND_READ,  8'd0,   8'd10,  32'd0,         1'b1, bhe_pkg::ANS_READ,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0},
    '{bhe_pkg::KIND_WRITE, 8'd0,   8'd20,  32'd0,         1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    '{bhe_pkg::KIND_WRITE, 8'd0,   8'd21,  32'hAAAA_AAAA, 1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    '{bhe_pkg::KIND_WRITE, 8'd0,   8'd22,  32'h5555_5555, 1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    // Spare codes with every payload bit set must change nothing.
    '{KIND_SPARE5, 8'd255, 8'd255, 32'hFFFF_FFFF, 1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    '{KIND_SPARE6, 8'd255, 8'd255, 32'hFFFF_FFFF, 1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    '{KIND_SPARE7, 8'd255, 8'd255, 32'hFFFF_FFFF, 1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    '{bhe_pkg::KIND_READ,  8'd0,   8'd0,   32'd0,         1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    '{bhe_pkg::KIND_SCAN,  8'd0,   8'd0,   32'd0,         1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    // Clear brings back the reset extremes.
    '{bhe_pkg::KIND_CLEAR, 8'd0,   8'd0,   32'd0,         1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    '{bhe_pkg::KIND_READ,  8'd0,   8'd10,  32'd0,         1'b1, bhe_pkg::ANS_READ,
      32'd0, 32'd0, 32'hFFFF_FFFF},
    // The first write raises largest, so smallest must not move with it.
    '{bhe_pkg::KIND_WRITE, 8'd0,   8'd3,   32'd7,         1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    '{bhe_pkg::KIND_WRITE, 8'd0,   8'd4,   32'd3,         1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    '{bhe_pkg::KIND_READ,  8'd0,   8'd3,   32'd0,         1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    '{bhe_pkg::KIND_ADD,   8'd128, 8'd0,   32'd0,         1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    '{bhe_pkg::KIND_SCAN,  8'd0,   8'd0,   32'd0,         1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0},
    '{bhe_pkg::KIND_READ,  8'd0,   8'd128, 32'd0,         1'b0, bhe_pkg::ANS_SCAN,
      32'd0, 32'd0, 32'd0}
  };

  logic clk;
  logic rst_n;

  bhe_in_if  in_chan ();
  bhe_out_if out_chan ();

  byte_histogram_engine_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Predictor state: a private copy of the bins and the two extremes.
  logic [CNT_W-1:0] hist_bins [BINS];
  logic [CNT_W-1:0] hist_largest;
  logic [CNT_W-1:0] hist_smallest;

  answer_t    pending_answers [$];
  int         mismatches;
  int         answers_checked;
  int         kind_seen [8];
  int         burst_left;
  logic [7:0] hot_bins [4];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: %0d answers still outstanding", pending_answers.size());
    $display("byte_histogram_engine_top_tb NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Applies one command to the predictor state. Returns 1 and fills the
  // answer when the command produces one (scans and reads).
  function automatic bit histogram_step(input command_t c, output answer_t a);
    logic [CNT_W-1:0] v;
    bit               answers;
    answers = 1'b0;
    a       = '0;
    v       = c.bin_value[CNT_W-1:0];
    case (c.kind)
      bhe_pkg::KIND_CLEAR: begin
        foreach (hist_bins[b]) hist_bins[b] = '0;
        hist_largest  = '0;
        hist_smallest = COUNT_MAX;
      end
      bhe_pkg::KIND_ADD: begin
        if (int'(c.voxel) < BINS && hist_bins[c.voxel] != COUNT_MAX)
          hist_bins[c.voxel] = hist_bins[c.voxel] + 1'b1;
      end
      bhe_pkg::KIND_SCAN: begin
        // Both compares apply to every bin; the extremes start from scratch.
        hist_largest  = '0;
        hist_smallest = COUNT_MAX;
        foreach (hist_bins[b]) begin
          if (hist_bins[b] > hist_largest)  hist_largest  = hist_bins[b];
          if (hist_bins[b] < hist_smallest) hist_smallest = hist_bins[b];
        end
        a       = '{bhe_pkg::ANS_SCAN, '0, hist_largest, hist_smallest};
        answers = 1'b1;
      end
      bhe_pkg::KIND_READ: begin
        a.answer_kind    = bhe_pkg::ANS_READ;
        a.bin_count      = (int'(c.bin_index) < BINS) ? hist_bins[c.bin_index] : '0;
        a.largest_count  = hist_largest;
        a.smallest_count = hist_smallest;
        answers          = 1'b1;
      end
      bhe_pkg::KIND_WRITE: begin
        // A written count only touches smallest when it did not raise largest.
        if (int'(c.bin_index) < BINS) begin
          hist_bins[c.bin_index] = v;
          if (v > hist_largest)       hist_largest  = v;
          else if (v < hist_smallest) hist_smallest = v;
        end
      end
      default: ;
    endcase
    return answers;
  endfunction

  // Presents one command, holding it until the engine accepts it. Bursts of
  // random length are separated by random gaps with valid low. On acceptance
  // the predictor runs and, if an answer is due, queues it (or the typed one).
  task automatic send_command(input command_t c, input bit typed, input answer_t typed_ans);
    answer_t predicted;
    int      gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid     <= 1'b1;
    in_chan.kind      <= c.kind;
    in_chan.voxel     <= c.voxel;
    in_chan.bin_index <= c.bin_index;
    in_chan.bin_value <= c.bin_value;
    do @(posedge clk); while (!in_chan.ready);
    kind_seen[c.kind]++;
    if (histogram_step(c, predicted))
      pending_answers.push_back(typed ? typed_ans : predicted);
  endtask

  // Holds the command channel idle until every queued answer has come back.
  // At least one edge always passes, so valid is never dropped and raised
  // again within the same time step.
  task automatic drain_answers();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  // Answer side: ready follows a pattern that is picked anew at random intervals:
  // always ready, coin flips, a fixed duty cycle, or long stalls.
  int stall_mode;
  int stall_left;
  int stall_tick;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      0:       out_chan.ready <= 1'b1;
      1:       out_chan.ready <= 1'($urandom_range(0, 1));
      2:       out_chan.ready <= (stall_tick % 7) < 3;
      default: out_chan.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Answer checker: every accepted answer is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected answer kind=%0b count=%h largest=%h smallest=%h",
                                  out_chan.answer_kind, out_chan.bin_count,
                                  out_chan.largest_count, out_chan.smallest_count));
      end else begin
        want = pending_answers.pop_front();
        answers_checked++;
        if (out_chan.answer_kind !== want.answer_kind)
          report_mismatch($sformatf("answer_kind %0b, expected %0b",
                                    out_chan.answer_kind, want.answer_kind));
        if (out_chan.bin_count !== want.bin_count)
          report_mismatch($sformatf("bin_count %h, expected %h",
                                    out_chan.bin_count, want.bin_count));
        if (out_chan.largest_count !== want.largest_count)
          report_mismatch($sformatf("largest_count %h, expected %h",
                                    out_chan.largest_count, want.largest_count));
        if (out_chan.smallest_count !== want.smallest_count)
          report_mismatch($sformatf("smallest_count %h, expected %h",
                                    out_chan.smallest_count, want.smallest_count));
      end
    end
  end

  initial begin
    command_t c;
    answer_t  typed_ans;
    int       random_sent;
    int       pick;

    in_chan.valid     <= 1'b0;
    in_chan.kind      <= bhe_pkg::KIND_CLEAR;
    in_chan.voxel     <= '0;
    in_chan.bin_index <= '0;
    in_chan.bin_value <= '0;
    rst_n             <= 1'b0;
    mismatches      = 0;
    answers_checked = 0;
    burst_left      = 0;
    stall_mode      = 0;
    stall_left      = 0;
    stall_tick      = 0;
    random_sent     = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    foreach (hot_bins[h]) hot_bins[h] = 8'($urandom_range(0, 255));

    // The predictor starts from the reset state of the engine.
    foreach (hist_bins[b]) hist_bins[b] = '0;
    hist_largest  = '0;
    hist_smallest = COUNT_MAX;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table. The engine runs its clearing pass first; the handshake
    // simply waits for it.
    foreach (DIRECTED_ROWS[r]) begin
      c = '{DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].voxel,
            DIRECTED_ROWS[r].bin_index, DIRECTED_ROWS[r].bin_value};
      typed_ans = '{DIRECTED_ROWS[r].answer_kind, DIRECTED_ROWS[r].bin_count,
                    DIRECTED_ROWS[r].largest_count, DIRECTED_ROWS[r].smallest_count};
      send_command(c, DIRECTED_ROWS[r].typed, typed_ans);
    end
    drain_answers();

    // Random mix. Half of the traffic is voxel adds, most of them aimed at a
    // few hot bins so that equal bins arrive back to back and writes near the
    // top of the range lead into saturation. Spare codes are thrown in as
    // noise and count toward the total like any other transaction.
    while (random_sent < RANDOM_CMDS) begin
      if (random_sent == RANDOM_CMDS / 2 || $urandom_range(0, 199) == 0)
        drain_answers();
      c.voxel     = ($urandom_range(0, 9) < 6) ? hot_bins[$urandom_range(0, 3)]
                                               : 8'($urandom_range(0, 255));
      c.bin_index = ($urandom_range(0, 1) == 0) ? hot_bins[$urandom_range(0, 3)]
                                                : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        0:       c.bin_value = $urandom;
        1:       c.bin_value = $urandom_range(0, 40);
        2:       c.bin_value = 32'hFFFF_FFFF - $urandom_range(0, 3);
        default: c.bin_value = '0;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 50)      c.kind = bhe_pkg::KIND_ADD;
      else if (pick < 68) c.kind = bhe_pkg::KIND_READ;
      else if (pick < 81) c.kind = bhe_pkg::KIND_WRITE;
      else if (pick < 87) c.kind = bhe_pkg::KIND_SCAN;
      else if (pick < 89) c.kind = bhe_pkg::KIND_CLEAR;
      else c.kind = bhe_pkg::KIND_W'($urandom_range(KIND_SPARE5, KIND_SPARE7));
      send_command(c, 1'b0, '0);
      random_sent++;
    end

    // Wait for the last answers, then keep clocking so that anything spurious
    // can show up.
    drain_answers();
    repeat (BINS + 16) @(posedge clk);

    $display("Ran %0d clears, %0d adds, %0d scans, %0d reads, %0d writes, %0d spare codes.",
             kind_seen[bhe_pkg::KIND_CLEAR], kind_seen[bhe_pkg::KIND_ADD],
             kind_seen[bhe_pkg::KIND_SCAN], kind_seen[bhe_pkg::KIND_READ],
             kind_seen[bhe_pkg::KIND_WRITE],
             kind_seen[KIND_SPARE5] + kind_seen[KIND_SPARE6] + kind_seen[KIND_SPARE7]);
    $display("Checked %0d answers, %0d mismatches.", answers_checked, mismatches);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("byte_histogram_engine_top_tb OK");
    end else begin
      $display("byte_histogram_engine_top_tb NOT OK");
    end
    $finish;
  end

endmodule
